// ===== hdl/kps_pkg.sv =====
// shared types, constants and microcode table for the keyframe playhead sampler
`default_nettype none
package kps_pkg;

    // field widths
    localparam int TIME_W  = 40;
    localparam int POS_W   = 48;
    localparam int FRAME_W = 11;
    localparam int FRAC_W  = 17;
    localparam int PER_W   = 24;
    localparam int RATE_W  = 16;
    localparam int MODE_W  = 2;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 2;

    // advance multiplier works on the time delta in two halves
    localparam int HALF_W    = TIME_W / 2;
    localparam int PROD_W    = HALF_W + RATE_W;
    localparam int ACC_W     = TIME_W + RATE_W;
    localparam int ADV_SHIFT = 12;

    // divider: span fits 36 bits, quotient is frame index and 16 fraction bits
    localparam int SPAN_W    = 36;
    localparam int FRAC_BITS = 16;
    localparam int QUO_W     = 28;
    localparam int FIDX_W    = QUO_W - FRAC_BITS;
    localparam int MOD_STEPS = POS_W / 2;
    localparam int DIV_STEPS = QUO_W / 2;
    localparam int CNT_W     = 5;

    localparam logic [FRAME_W-1:0] MAX_INTERVALS = 11'd1024;
    localparam logic [FRAC_W-1:0]  FRAC_ONE      = 17'h10000;

    // play modes
    localparam logic [MODE_W-1:0] MODE_LOOP   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SINGLE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MIRROR = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RAW    = 2'd3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_PLAY_MODE      = 2'd0;
    localparam logic [IDX_W-1:0] REG_INTERVAL_COUNT = 2'd1;
    localparam logic [IDX_W-1:0] REG_FRAME_PERIOD   = 2'd2;
    localparam logic [IDX_W-1:0] REG_PLAYBACK_RATE  = 2'd3;

    localparam logic [PER_W-1:0]  FRAME_PERIOD_RST  = 24'd2185;
    localparam logic [RATE_W-1:0] PLAYBACK_RATE_RST = 16'd4096;

    typedef struct packed {
        logic [MODE_W-1:0]  play_mode;
        logic [FRAME_W-1:0] interval_count;
        logic [PER_W-1:0]   frame_period;
        logic [RATE_W-1:0]  playback_rate;
    } cfg_t;

    // microprogram addresses
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE     = 4'd0;
    localparam step_t STEP_PREP     = 4'd1;
    localparam step_t STEP_MUL_LO   = 4'd2;
    localparam step_t STEP_MUL_HI   = 4'd3;
    localparam step_t STEP_ACC      = 4'd4;
    localparam step_t STEP_ADV      = 4'd5;
    localparam step_t STEP_SPAN     = 4'd6;
    localparam step_t STEP_GUARD    = 4'd7;
    localparam step_t STEP_MOD_INIT = 4'd8;
    localparam step_t STEP_MOD_LOOP = 4'd9;
    localparam step_t STEP_MOD_DONE = 4'd10;
    localparam step_t STEP_CLAMP    = 4'd11;
    localparam step_t STEP_DIV_INIT = 4'd12;
    localparam step_t STEP_DIV_LOOP = 4'd13;
    localparam step_t STEP_FRAC     = 4'd14;
    localparam step_t STEP_OUT      = 4'd15;

    typedef enum logic [3:0] {
        OP_IDLE     = 4'd0,
        OP_PREP     = 4'd1,
        OP_MUL_LO   = 4'd2,
        OP_MUL_HI   = 4'd3,
        OP_ACC      = 4'd4,
        OP_ADV      = 4'd5,
        OP_SPAN     = 4'd6,
        OP_GUARD    = 4'd7,
        OP_MOD_INIT = 4'd8,
        OP_DIV_STEP = 4'd9,
        OP_MOD_DONE = 4'd10,
        OP_CLAMP    = 4'd11,
        OP_DIV_INIT = 4'd12,
        OP_FRAC     = 4'd13,
        OP_OUT      = 4'd14
    } op_t;

    typedef enum logic [2:0] {
        COND_NEXT     = 3'd0,
        COND_ALWAYS   = 3'd1,
        COND_NO_INPUT = 3'd2,
        COND_NO_FOLD  = 3'd3,
        COND_SINGLE   = 3'd4,
        COND_CNT_NZ   = 3'd5,
        COND_OUT_BUSY = 3'd6
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } uword_t;

    typedef struct packed {
        logic no_fold;
        logic single;
        logic cnt_nz;
        logic out_busy;
    } dp_status_t;

    // control store: jump to target when the condition holds, else fall through
    function automatic uword_t ucode_rom(input step_t step);
        uword_t w;
        case (step)
            STEP_IDLE:     w = '{OP_IDLE,     COND_NO_INPUT, STEP_IDLE};
            STEP_PREP:     w = '{OP_PREP,     COND_NEXT,     STEP_IDLE};
            STEP_MUL_LO:   w = '{OP_MUL_LO,   COND_NEXT,     STEP_IDLE};
            STEP_MUL_HI:   w = '{OP_MUL_HI,   COND_NEXT,     STEP_IDLE};
            STEP_ACC:      w = '{OP_ACC,      COND_NEXT,     STEP_IDLE};
            STEP_ADV:      w = '{OP_ADV,      COND_NEXT,     STEP_IDLE};
            STEP_SPAN:     w = '{OP_SPAN,     COND_NEXT,     STEP_IDLE};
            STEP_GUARD:    w = '{OP_GUARD,    COND_NO_FOLD,  STEP_OUT};
            STEP_MOD_INIT: w = '{OP_MOD_INIT, COND_SINGLE,   STEP_CLAMP};
            STEP_MOD_LOOP: w = '{OP_DIV_STEP, COND_CNT_NZ,   STEP_MOD_LOOP};
            STEP_MOD_DONE: w = '{OP_MOD_DONE, COND_ALWAYS,   STEP_DIV_INIT};
            STEP_CLAMP:    w = '{OP_CLAMP,    COND_NEXT,     STEP_IDLE};
            STEP_DIV_INIT: w = '{OP_DIV_INIT, COND_NEXT,     STEP_IDLE};
            STEP_DIV_LOOP: w = '{OP_DIV_STEP, COND_CNT_NZ,   STEP_DIV_LOOP};
            STEP_FRAC:     w = '{OP_FRAC,     COND_NEXT,     STEP_IDLE};
            // last address: falling through wraps back to idle
            STEP_OUT:      w = '{OP_OUT,      COND_OUT_BUSY, STEP_OUT};
            default:       w = '{OP_IDLE,     COND_ALWAYS,   STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/kps_sequencer.sv =====
// microprogram sequencer: step counter, control store and conditional jumps
`default_nettype none
module kps_sequencer (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               accept,
    input  wire kps_pkg::dp_status_t status,
    output kps_pkg::op_t            op
);
    import kps_pkg::*;

    step_t  pc_reg;
    step_t  pc_next;
    uword_t word;
    logic   take;

    assign word = ucode_rom(pc_reg);
    assign op   = word.op;

    always_comb begin
        case (word.cond)
            COND_NEXT:     take = 1'b0;
            COND_ALWAYS:   take = 1'b1;
            COND_NO_INPUT: take = !accept;
            COND_NO_FOLD:  take = status.no_fold;
            COND_SINGLE:   take = status.single;
            COND_CNT_NZ:   take = status.cnt_nz;
            COND_OUT_BUSY: take = status.out_busy;
            default:       take = 1'b0;
        endcase
        pc_next = take ? word.target : pc_reg + step_t'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= STEP_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/kps_datapath.sv =====
// datapath: advance and span multipliers, radix-4 shared divider, fold logic, result register
`default_nettype none
module kps_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire kps_pkg::op_t                  op,
    input  wire logic                          accept,
    input  wire logic [kps_pkg::TIME_W-1:0]    elapsed_time,
    input  wire kps_pkg::cfg_t                 cfg,
    input  wire logic                          m_ready,
    output logic                               m_valid,
    output logic [kps_pkg::FRAME_W-1:0]        m_first_frame,
    output logic [kps_pkg::FRAME_W-1:0]        m_second_frame,
    output logic [kps_pkg::FRAC_W-1:0]         m_blend_fraction,
    output logic [kps_pkg::POS_W-1:0]          m_position_out,
    output kps_pkg::dp_status_t                status
);
    import kps_pkg::*;

    // playhead state
    logic                started_reg;
    logic [TIME_W-1:0]   last_reg;
    logic [POS_W-1:0]    pos_reg;

    // work registers
    logic [TIME_W-1:0]   now_reg;
    logic [TIME_W-1:0]   delta_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [SPAN_W-1:0]   span_reg;
    logic [SPAN_W-1:0]   dsr_reg;
    logic [SPAN_W-1:0]   rem_reg;
    logic [POS_W-1:0]    dvd_reg;
    logic [QUO_W-1:0]    quo_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [FRAME_W-1:0]  fa_reg;
    logic [FRAME_W-1:0]  fb_reg;
    logic [FRAC_W-1:0]   frac_reg;

    // result register
    logic                m_valid_reg;
    logic [FRAME_W-1:0]  m_fa_reg;
    logic [FRAME_W-1:0]  m_fb_reg;
    logic [FRAC_W-1:0]   m_frac_reg;
    logic [POS_W-1:0]    m_pos_reg;

    logic                forward;
    logic                out_busy;
    logic [FRAME_W-1:0]  lenc;
    logic                len_zero;
    logic [FIDX_W-1:0]   span_len;
    logic [SPAN_W-1:0]   span_prod;
    logic [PROD_W-1:0]   prod_lo;
    logic [PROD_W-1:0]   prod_hi;
    logic [POS_W:0]      pos_sum;

    logic [SPAN_W-1:0]   r_next;
    logic [POS_W-1:0]    d_next;
    logic [QUO_W-1:0]    q_next;
    logic [SPAN_W:0]     trial;

    logic [FIDX_W-1:0]   idx;
    logic [FIDX_W-1:0]   idx1;
    logic [FIDX_W-1:0]   len12;
    logic [FIDX_W-1:0]   len2;
    logic [FIDX_W-1:0]   fold_a;
    logic [FIDX_W-1:0]   fold_b;
    logic [FRAME_W-1:0]  fa_new;
    logic [FRAME_W-1:0]  fb_new;
    logic [FRAC_W-1:0]   frac_new;

    assign forward  = now_reg > last_reg;
    assign out_busy = m_valid_reg && !m_ready;

    assign lenc     = (cfg.interval_count > MAX_INTERVALS) ? MAX_INTERVALS
                                                           : cfg.interval_count;
    assign len_zero = (lenc == '0) || (cfg.frame_period == '0);
    assign span_len = (cfg.play_mode == MODE_MIRROR) ? {lenc, 1'b0} : {1'b0, lenc};
    assign span_prod = span_len * cfg.frame_period;

    assign prod_lo = delta_reg[HALF_W-1:0] * cfg.playback_rate;
    assign prod_hi = delta_reg[TIME_W-1:HALF_W] * cfg.playback_rate;
    assign pos_sum = {1'b0, pos_reg} + (POS_W+1)'(acc_reg[ACC_W-1:ADV_SHIFT]);

    assign status.no_fold  = (cfg.play_mode == MODE_RAW) || len_zero;
    assign status.single   = (cfg.play_mode == MODE_SINGLE);
    assign status.cnt_nz   = (cnt_reg != '0);
    assign status.out_busy = out_busy;

    // two restoring quotient bits per cycle
    always_comb begin
        r_next = rem_reg;
        d_next = dvd_reg;
        q_next = quo_reg;
        for (int i = 0; i < 2; i++) begin
            trial  = {r_next, d_next[POS_W-1]};
            d_next = {d_next[POS_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg}) begin
                trial  = trial - {1'b0, dsr_reg};
                q_next = {q_next[QUO_W-2:0], 1'b1};
            end else begin
                q_next = {q_next[QUO_W-2:0], 1'b0};
            end
            r_next = trial[SPAN_W-1:0];
        end
    end

    // quotient of position * 2^16 / period holds frame index over fraction
    always_comb begin
        idx      = quo_reg[QUO_W-1:FRAC_BITS];
        idx1     = idx + FIDX_W'(1);
        len12    = {1'b0, lenc};
        len2     = {lenc, 1'b0};
        fold_a   = (idx > len12) ? len2 - idx : idx;
        fold_b   = (idx1 > len12) ? len2 - idx1 : idx1;
        fa_new   = idx[FRAME_W-1:0];
        fb_new   = idx1[FRAME_W-1:0];
        frac_new = {1'b0, quo_reg[FRAC_BITS-1:0]};
        case (cfg.play_mode)
            MODE_SINGLE: begin
                // past the end: hold the last interval at full weight
                if (idx >= len12) begin
                    fa_new   = lenc - FRAME_W'(1);
                    fb_new   = lenc;
                    frac_new = FRAC_ONE;
                end
            end
            MODE_MIRROR: begin
                fa_new = fold_a[FRAME_W-1:0];
                fb_new = fold_b[FRAME_W-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
            last_reg    <= '0;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (op != OP_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (op)
                OP_PREP: begin
                    if (!started_reg) begin
                        started_reg <= 1'b1;
                        last_reg    <= now_reg;
                    end else if (forward) begin
                        last_reg <= now_reg;
                    end
                end
                OP_ADV: begin
                    pos_reg <= pos_sum[POS_W] ? '1 : pos_sum[POS_W-1:0];
                end
                OP_GUARD: begin
                    if (len_zero && (cfg.play_mode != MODE_RAW)) begin
                        pos_reg <= '0;
                    end
                end
                OP_MOD_DONE: begin
                    pos_reg <= POS_W'(rem_reg);
                end
                OP_CLAMP: begin
                    if (pos_reg > POS_W'(span_reg)) begin
                        pos_reg <= POS_W'(span_reg);
                    end
                end
                OP_OUT: begin
                    if (!out_busy) begin
                        m_valid_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (op)
            OP_IDLE: begin
                if (accept) begin
                    now_reg <= elapsed_time;
                end
            end
            OP_PREP: begin
                delta_reg <= (started_reg && forward) ? now_reg - last_reg : '0;
            end
            OP_MUL_LO: begin
                acc_reg <= ACC_W'(prod_lo);
            end
            OP_MUL_HI: begin
                prod_reg <= prod_hi;
            end
            OP_ACC: begin
                acc_reg <= acc_reg + {prod_reg, {HALF_W{1'b0}}};
            end
            OP_SPAN: begin
                span_reg <= span_prod;
            end
            OP_GUARD: begin
                fa_reg   <= '0;
                fb_reg   <= '0;
                frac_reg <= '0;
            end
            OP_MOD_INIT: begin
                rem_reg <= '0;
                dvd_reg <= pos_reg;
                dsr_reg <= span_reg;
                cnt_reg <= CNT_W'(MOD_STEPS - 1);
            end
            OP_DIV_STEP: begin
                rem_reg <= r_next;
                dvd_reg <= d_next;
                quo_reg <= q_next;
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            OP_DIV_INIT: begin
                // dividend is position << 16; its top bits seed the remainder
                rem_reg <= pos_reg[POS_W-1:FIDX_W];
                dvd_reg <= {pos_reg[FIDX_W-1:0], {(POS_W-FIDX_W){1'b0}}};
                dsr_reg <= SPAN_W'(cfg.frame_period);
                quo_reg <= '0;
                cnt_reg <= CNT_W'(DIV_STEPS - 1);
            end
            OP_FRAC: begin
                fa_reg   <= fa_new;
                fb_reg   <= fb_new;
                frac_reg <= frac_new;
            end
            OP_OUT: begin
                if (!out_busy) begin
                    m_fa_reg   <= fa_reg;
                    m_fb_reg   <= fb_reg;
                    m_frac_reg <= frac_reg;
                    m_pos_reg  <= pos_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_valid          = m_valid_reg;
    assign m_first_frame    = m_fa_reg;
    assign m_second_frame   = m_fb_reg;
    assign m_blend_fraction = m_frac_reg;
    assign m_position_out   = m_pos_reg;

endmodule
`default_nettype wire

// ===== hdl/keyframe_playhead_sampler.sv =====
// top level of the keyframe playhead sampler: config registers, handshakes, sequencer and datapath
//
//  channel  | valid / ready      | payload
//  ---------+--------------------+------------------------------------------------
//  input    | s_valid / s_ready  | s_elapsed_time
//  result   | m_valid / m_ready  | m_first_frame, m_second_frame,
//           |                    | m_blend_fraction, m_position_out
//  config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  one request at a time: loop and mirror run both shared divider loops, first the
//  wrap and then index and fraction; single play skips the wrap and clamps instead,
//  and zero length, zero period or mode three skip both. the divider produces two
//  quotient bits per cycle. reset is synchronous and needs no clearing pass.
//  a result waiting in the output register does not block the next accept; the
//  sequencer only stalls at its final step while that register is still full.
`default_nettype none
module keyframe_playhead_sampler (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [kps_pkg::TIME_W-1:0]    s_elapsed_time,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [kps_pkg::FRAME_W-1:0]        m_first_frame,
    output logic [kps_pkg::FRAME_W-1:0]        m_second_frame,
    output logic [kps_pkg::FRAC_W-1:0]         m_blend_fraction,
    output logic [kps_pkg::POS_W-1:0]          m_position_out,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [kps_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [kps_pkg::CFG_W-1:0]     cfg_data
);
    import kps_pkg::*;

    cfg_t       cfg_reg;
    op_t        op;
    dp_status_t status;
    logic       accept;

    assign cfg_ready = 1'b1;
    assign s_ready   = (op == OP_IDLE);
    assign accept    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.play_mode      <= MODE_LOOP;
            cfg_reg.interval_count <= '0;
            cfg_reg.frame_period   <= FRAME_PERIOD_RST;
            cfg_reg.playback_rate  <= PLAYBACK_RATE_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_PLAY_MODE:      cfg_reg.play_mode      <= cfg_data[MODE_W-1:0];
                REG_INTERVAL_COUNT: cfg_reg.interval_count <= cfg_data[FRAME_W-1:0];
                REG_FRAME_PERIOD:   cfg_reg.frame_period   <= cfg_data[PER_W-1:0];
                REG_PLAYBACK_RATE:  cfg_reg.playback_rate  <= cfg_data[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    kps_sequencer u_sequencer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .status  (status),
        .op      (op)
    );

    kps_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .op               (op),
        .accept           (accept),
        .elapsed_time     (s_elapsed_time),
        .cfg              (cfg_reg),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_first_frame    (m_first_frame),
        .m_second_frame   (m_second_frame),
        .m_blend_fraction (m_blend_fraction),
        .m_position_out   (m_position_out),
        .status           (status)
    );

endmodule
`default_nettype wire

// ===== hdl/kps_checker.sv =====
// port-level assertions for the keyframe playhead sampler, bound to the top level
`default_nettype none
module kps_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [kps_pkg::FRAME_W-1:0]   m_first_frame,
    input wire logic [kps_pkg::FRAME_W-1:0]   m_second_frame,
    input wire logic [kps_pkg::FRAC_W-1:0]    m_blend_fraction,
    input wire logic [kps_pkg::POS_W-1:0]     m_position_out
);
    import kps_pkg::*;

    // one request in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a request was still being worked");

    // a waiting result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_position_out)
                                   && $stable(m_first_frame)
                                   && $stable(m_blend_fraction)))
        else $error("result dropped or changed while stalled");

    // no result survives reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // frames stay within a track and the fraction within one
    a_result_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_blend_fraction <= FRAC_ONE && m_first_frame <= MAX_INTERVALS
                     && m_second_frame <= MAX_INTERVALS))
        else $error("result field out of range");

    // full weight must fall on two adjacent frames, as on the last interval past the end of single play
    a_full_weight: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_blend_fraction == FRAC_ONE)
            |-> (m_second_frame == m_first_frame + FRAME_W'(1)))
        else $error("full weight on an interval that is not adjacent");

endmodule

bind keyframe_playhead_sampler kps_checker u_kps_checker (.*);
`default_nettype wire
